FILE: rtl/gbt_pkg.sv
// Shared types and constants of the graph traversal engine.
package gbt_pkg;

    localparam int VERTEX_W     = 4;
    localparam int MAX_VERTICES = 16;
    localparam int COUNT_W      = 5;
    localparam int COMMAND_W    = 2;
    localparam int STATUS_W     = 2;
    localparam int FPTR_W       = $clog2(MAX_VERTICES + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [COUNT_W-1:0] RESET_VERTEX_COUNT = COUNT_W'(MAX_VERTICES);

    typedef enum logic [COMMAND_W-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_BFS      = 2'd1,
        CMD_DFS      = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        command_t            kind;
        logic                range_err;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHK_A,
        BK_CHK_B,
        BK_WR_A,
        BK_WR_B,
        BK_EDGE_OUT,
        BK_T_INIT,
        BK_T_POP,
        BK_T_DEG,
        BK_T_SCAN,
        BK_T_OUT
    } back_state_t;

endpackage

FILE: rtl/gbt_if.sv
// Valid/ready channel interfaces for command words and result words.
interface gbt_cmd_if
    import gbt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COMMAND_W-1:0] command;
    logic [VERTEX_W-1:0]  vertex_a;
    logic [VERTEX_W-1:0]  vertex_b;

    modport source (output valid, command, vertex_a, vertex_b, input ready);
    modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface gbt_res_if
    import gbt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] vertex;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, vertex, status, last, input ready);
    modport sink   (input valid, vertex, status, last, output ready);
endinterface

FILE: rtl/graph_bfs_dfs_traversal.sv
// An edge word runs through CHK_A, CHK_B, WR_A, WR_B and EDGE_OUT, which registers its
// status word (EDGE_OUT alone for an endpoint out of range; CHK_A, CHK_B, EDGE_OUT for
// a full list). Traversal: an init state, then per reached vertex POP, DEG, SCAN, OUT;
// SCAN takes one adjacency entry per cycle through the adjacency RAM read port.
// Words run one at a time, output stalls hold them, and up to two words queue in front.
// Reset (async, active low) clears degrees, visited bits, queue; vertex count goes to 16.
module graph_bfs_dfs_traversal
    import gbt_pkg::*;
#(
    parameter int MAX_DEGREE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    gbt_cmd_if.sink            req,
    gbt_res_if.source          rsp,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic push, push_ready, pop, pop_valid;
    job_t push_job, pop_job;

    gbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    gbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    gbt_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/gbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gbt_queue.sv
// Two-entry job queue between the front end and the execution engine.
module gbt_queue
    import gbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    job_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = q_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/gbt_front.sv
// Front end: takes command words, holds the vertex count register, range-checks edges.
module gbt_front
    import gbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gbt_cmd_if.sink            req,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               push,
    output job_t               push_job,
    input  logic               push_ready
);

    logic [COUNT_W-1:0] vertex_count_reg, vertex_count_next;
    logic [COUNT_W-1:0] eff_count;
    logic               known_cmd;

    assign vertex_count_next = cfg_write ? cfg_data : vertex_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= RESET_VERTEX_COUNT;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    // A count of zero behaves as one, anything above the vertex limit as the limit.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (vertex_count_reg > COUNT_W'(MAX_VERTICES))
        begin
            eff_count = COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            eff_count = vertex_count_reg;
        end
    end

    // The unused command code is swallowed here and never reaches the queue.
    assign known_cmd = req.command inside {CMD_ADD_EDGE, CMD_BFS, CMD_DFS};

    assign req.ready = push_ready;
    assign push      = req.valid && push_ready && known_cmd;

    always_comb
    begin
        push_job.kind      = command_t'(req.command);
        push_job.vertex_a  = req.vertex_a;
        push_job.vertex_b  = req.vertex_b;
        push_job.range_err = ({1'b0, req.vertex_a} >= eff_count)
                          || ({1'b0, req.vertex_b} >= eff_count);
    end

endmodule

FILE: rtl/gbt_back.sv
// Execution engine: edge insertion and breadth- or depth-first traversal.
module gbt_back
    import gbt_pkg::*;
#(
    parameter int MAX_DEGREE = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  job_t     job,
    output logic     job_pop,
    gbt_res_if.source rsp
);

    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int ADDR_W = VERTEX_W + SLOT_W;
    localparam int DEPTH  = MAX_VERTICES << SLOT_W;
    localparam logic [DEG_W-1:0] MD_D = DEG_W'(MAX_DEGREE);
    localparam logic [DEG_W:0]   MD_X = (DEG_W + 1)'(MAX_DEGREE);

    back_state_t state_reg, state_next;

    logic [VERTEX_W-1:0] a_reg, a_next;
    logic [VERTEX_W-1:0] b_reg, b_next;
    logic [VERTEX_W-1:0] cur_reg, cur_next;
    logic                dfs_reg, dfs_next;
    logic                full_reg, full_next;
    status_t             status_reg, status_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic [DEG_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [FPTR_W-1:0]   head_reg, head_next;
    logic [FPTR_W-1:0]   tail_reg, tail_next;
    logic                out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0] out_vertex_reg, out_vertex_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic [DEG_W-1:0]    degree_reg [MAX_VERTICES];
    logic [VERTEX_W-1:0] frontier_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;

    logic [VERTEX_W-1:0] deg_rv;
    logic [DEG_W-1:0]    deg_rd;
    logic                deg_we;
    logic [VERTEX_W-1:0] deg_wv;
    logic [DEG_W-1:0]    deg_wdata;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VERTEX_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VERTEX_W-1:0] ram_rdata;

    logic                fr_we;
    logic [VERTEX_W-1:0] fr_widx;
    logic [VERTEX_W-1:0] fr_wdata;
    logic [VERTEX_W-1:0] fr_ridx;
    logic [FPTR_W-1:0]   tail_m1;

    logic                vis_clear;
    logic                vis_set;
    logic                out_free;
    logic                empty;

    gbt_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign empty    = (head_reg == tail_reg);
    assign tail_m1  = tail_reg - FPTR_W'(1);
    assign fr_ridx  = dfs_reg ? tail_m1[VERTEX_W-1:0] : head_reg[VERTEX_W-1:0];

    always_comb
    begin
        case (state_reg)
            BK_CHK_B, BK_WR_B: deg_rv = b_reg;
            BK_T_DEG:          deg_rv = cur_reg;
            default:           deg_rv = a_reg;
        endcase
    end

    assign deg_rd = degree_reg[deg_rv];

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cur_next        = cur_reg;
        dfs_next        = dfs_reg;
        full_next       = full_reg;
        status_next     = status_reg;
        deg_next        = deg_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_vertex_next = out_vertex_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        job_pop         = 1'b0;
        deg_we          = 1'b0;
        deg_wv          = a_reg;
        deg_wdata       = deg_rd + DEG_W'(1);
        ram_we          = 1'b0;
        ram_waddr       = {a_reg, deg_rd[SLOT_W-1:0]};
        ram_wdata       = b_reg;
        ram_raddr       = {cur_reg, issue_reg[SLOT_W-1:0]};
        fr_we           = 1'b0;
        fr_widx         = tail_reg[VERTEX_W-1:0];
        fr_wdata        = ram_rdata;
        vis_clear       = 1'b0;
        vis_set         = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    a_next      = job.vertex_a;
                    b_next      = job.vertex_b;
                    dfs_next    = (job.kind == CMD_DFS);
                    status_next = ST_OK;
                    case (job.kind)
                        CMD_ADD_EDGE:
                        begin
                            if (job.range_err)
                            begin
                                status_next = ST_RANGE;
                                state_next  = BK_EDGE_OUT;
                            end
                            else
                            begin
                                state_next = BK_CHK_A;
                            end
                        end
                        CMD_BFS, CMD_DFS: state_next = BK_T_INIT;
                        default:          state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CHK_A:
            begin
                // A self-loop needs two free slots in one list.
                if (a_reg == b_reg)
                begin
                    full_next = (({1'b0, deg_rd} + (DEG_W + 1)'(2)) > MD_X);
                end
                else
                begin
                    full_next = (deg_rd >= MD_D);
                end
                state_next = BK_CHK_B;
            end
            BK_CHK_B:
            begin
                if (full_reg || ((a_reg != b_reg) && (deg_rd >= MD_D)))
                begin
                    status_next = ST_FULL;
                    state_next  = BK_EDGE_OUT;
                end
                else
                begin
                    state_next = BK_WR_A;
                end
            end
            BK_WR_A:
            begin
                ram_we     = 1'b1;
                deg_we     = 1'b1;
                state_next = BK_WR_B;
            end
            BK_WR_B:
            begin
                // The degree of b is read after the update of a, so a self-loop lands in the next slot.
                ram_we     = 1'b1;
                ram_waddr  = {b_reg, deg_rd[SLOT_W-1:0]};
                ram_wdata  = a_reg;
                deg_we     = 1'b1;
                deg_wv     = b_reg;
                state_next = BK_EDGE_OUT;
            end
            BK_EDGE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = '0;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            BK_T_INIT:
            begin
                vis_clear  = 1'b1;
                fr_we      = 1'b1;
                fr_widx    = '0;
                fr_wdata   = '0;
                head_next  = '0;
                tail_next  = FPTR_W'(1);
                state_next = BK_T_POP;
            end
            BK_T_POP:
            begin
                cur_next = frontier_reg[fr_ridx];
                if (dfs_reg)
                begin
                    tail_next = tail_m1;
                end
                else
                begin
                    head_next = head_reg + FPTR_W'(1);
                end
                state_next = BK_T_DEG;
            end
            BK_T_DEG:
            begin
                deg_next   = deg_rd;
                issue_next = '0;
                pend_next  = 1'b0;
                state_next = BK_T_SCAN;
            end
            BK_T_SCAN:
            begin
                // Reads are issued one per cycle; each neighbor arrives in the cycle after its read.
                pend_next = (issue_reg < deg_reg);
                if (issue_reg < deg_reg)
                begin
                    issue_next = issue_reg + DEG_W'(1);
                end
                if (pend_reg && !visited_reg[ram_rdata]
                    && (tail_reg < FPTR_W'(MAX_VERTICES)))
                begin
                    vis_set   = 1'b1;
                    fr_we     = 1'b1;
                    tail_next = tail_reg + FPTR_W'(1);
                end
                if (!(issue_reg < deg_reg) && !pend_reg)
                begin
                    state_next = BK_T_OUT;
                end
            end
            BK_T_OUT:
            begin
                // The vertex goes out after its neighbors are pushed, so the last flag is known.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = cur_reg;
                    out_status_next = ST_OK;
                    out_last_next   = empty;
                    state_next      = empty ? BK_IDLE : BK_T_POP;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            visited_reg   <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                degree_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (vis_clear)
            begin
                visited_reg <= MAX_VERTICES'(1);
            end
            else if (vis_set)
            begin
                visited_reg[ram_rdata] <= 1'b1;
            end
            if (deg_we)
            begin
                degree_reg[deg_wv] <= deg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        cur_reg        <= cur_next;
        dfs_reg        <= dfs_next;
        full_reg       <= full_next;
        status_reg     <= status_next;
        deg_reg        <= deg_next;
        issue_reg      <= issue_next;
        out_vertex_reg <= out_vertex_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (fr_we)
        begin
            frontier_reg[fr_widx] <= fr_wdata;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.vertex = out_vertex_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

    a_frontier_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg <= FPTR_W'(MAX_VERTICES)) && (head_reg <= tail_reg))
        else $error("frontier pointers out of order");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_T_POP) |-> !empty)
        else $error("pop from an empty frontier");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_last_reg && (out_vertex_reg == '0)))
        else $error("edge status word without last flag or with a vertex");

    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        deg_we |-> (deg_rd < MD_D))
        else $error("adjacency list grown past its limit");

endmodule
